>>> rtl/dts_pkg.sv
// Shared types and constants for the deadline task scheduler.
// No dependencies; every other file refers to it by scoped names.
package dts_pkg;

    localparam int IdW    = 4;    // task id field
    localparam int DlyW   = 32;   // delay field
    localparam int ScaleW = 42;   // delay after the millisecond scale
    localparam int NdW    = 48;   // reported deadline
    localparam logic [9:0] MsScale = 10'd1000;

    typedef enum logic [1:0] {
        CMD_RUN_NOW   = 2'd0,
        CMD_RUN_AFTER = 2'd1,
        CMD_TICK      = 2'd2,
        CMD_POP       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_SHIFT  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_REMOVE,
        ST_INSERT,
        ST_EXPIRE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        op_t            op;
        logic [IdW-1:0] id;
    } chain_ctl_t;

endpackage

>>> rtl/dts_if.sv
// Request and response channel interfaces of the deadline task scheduler.
// Depends on dts_pkg for field widths.
interface dts_req_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic [dts_pkg::IdW-1:0]  task_id;
    logic [dts_pkg::DlyW-1:0] delay;
    logic                     delay_in_ms;

    modport source (output valid, command, task_id, delay, delay_in_ms, input ready);
    modport sink   (input valid, command, task_id, delay, delay_in_ms, output ready);
endinterface

interface dts_rsp_if;
    logic                    valid;
    logic                    ready;
    logic                    status;
    logic                    ready_valid;
    logic [dts_pkg::IdW-1:0] ready_task;
    logic                    ready_empty;
    logic                    waiting_empty;
    logic [dts_pkg::NdW-1:0] next_deadline;

    modport source (output valid, status, ready_valid, ready_task, ready_empty,
                    waiting_empty, next_deadline, input ready);
    modport sink   (input valid, status, ready_valid, ready_task, ready_empty,
                    waiting_empty, next_deadline, output ready);
endinterface

>>> rtl/dts_cell.sv
// One slot of the deadline-sorted waiting list.
// Depends on dts_pkg; apart from the shared control and new deadline, talks only to its two neighbors.
module dts_cell #(
    parameter int TIME_BITS = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dts_pkg::chain_ctl_t          ctl,
    input  logic [TIME_BITS-1:0]         new_dl,
    input  logic                         prev_valid,
    input  logic [dts_pkg::IdW-1:0]      prev_id,
    input  logic [TIME_BITS-1:0]         prev_dl,
    input  logic                         prev_earlier,
    input  logic                         prev_found,
    input  logic                         next_valid,
    input  logic [dts_pkg::IdW-1:0]      next_id,
    input  logic [TIME_BITS-1:0]         next_dl,
    output logic                         valid,
    output logic [dts_pkg::IdW-1:0]      id,
    output logic [TIME_BITS-1:0]         dl,
    output logic                         earlier,
    output logic                         found
);
    logic                    valid_reg, valid_next;
    logic [dts_pkg::IdW-1:0] id_reg, id_next;
    logic [TIME_BITS-1:0]    dl_reg, dl_next;

    assign earlier = valid_reg && (dl_reg < new_dl);
    assign found   = prev_found || (valid_reg && (id_reg == ctl.id));

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        dl_next    = dl_reg;
        case (ctl.op)
            dts_pkg::OP_INSERT:
            begin
                // stay put if earlier; the first slot that is not earlier takes the newcomer
                if (!earlier)
                begin
                    if (prev_earlier)
                    begin
                        valid_next = 1'b1;
                        id_next    = ctl.id;
                        dl_next    = new_dl;
                    end
                    else
                    begin
                        valid_next = prev_valid;
                        id_next    = prev_id;
                        dl_next    = prev_dl;
                    end
                end
            end
            dts_pkg::OP_REMOVE:
            begin
                if (found)
                begin
                    valid_next = next_valid;
                    id_next    = next_id;
                    dl_next    = next_dl;
                end
            end
            dts_pkg::OP_SHIFT:
            begin
                valid_next = next_valid;
                id_next    = next_id;
                dl_next    = next_dl;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        dl_reg <= dl_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign dl    = dl_reg;
endmodule

>>> rtl/dts_wait_chain.sv
// Row of waiting-list cells, earliest deadline at slot 0.
// Depends on dts_pkg and dts_cell.
module dts_wait_chain #(
    parameter int NUM_TASKS = 16,
    parameter int TIME_BITS = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dts_pkg::chain_ctl_t     ctl,
    input  logic [TIME_BITS-1:0]    new_dl,
    output logic [NUM_TASKS-1:0]    valids,
    output logic [dts_pkg::IdW-1:0] head_id,
    output logic [TIME_BITS-1:0]    head_dl
);
    logic                    v   [NUM_TASKS+1];
    logic [dts_pkg::IdW-1:0] ids [NUM_TASKS+1];
    logic [TIME_BITS-1:0]    dls [NUM_TASKS+1];
    logic                    bef [NUM_TASKS+1];
    logic                    fnd [NUM_TASKS+1];

    // slot 0 sees a virtual earlier neighbor; the tail sees an empty one
    assign bef[0]         = 1'b1;
    assign fnd[0]         = 1'b0;
    assign v[NUM_TASKS]   = 1'b0;
    assign ids[NUM_TASKS] = '0;
    assign dls[NUM_TASKS] = '0;

    for (genvar i = 0; i < NUM_TASKS; i++)
    begin : g_cell
        logic                    pv;
        logic [dts_pkg::IdW-1:0] pid;
        logic [TIME_BITS-1:0]    pdl;
        if (i == 0)
        begin : g_first
            assign pv  = 1'b0;
            assign pid = '0;
            assign pdl = '0;
        end
        else
        begin : g_rest
            assign pv  = v[i-1];
            assign pid = ids[i-1];
            assign pdl = dls[i-1];
        end

        dts_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_dl      (new_dl),
            .prev_valid  (pv),
            .prev_id     (pid),
            .prev_dl     (pdl),
            .prev_earlier(bef[i]),
            .prev_found  (fnd[i]),
            .next_valid  (v[i+1]),
            .next_id     (ids[i+1]),
            .next_dl     (dls[i+1]),
            .valid       (v[i]),
            .id          (ids[i]),
            .dl          (dls[i]),
            .earlier     (bef[i+1]),
            .found       (fnd[i+1])
        );
        assign valids[i] = v[i];
    end

    assign head_id = ids[0];
    assign head_dl = dls[0];
endmodule

>>> rtl/deadline_task_scheduler.sv
// Deadline task scheduler top level: command sequencer, ready ring and task marks.
// Depends on dts_pkg, dts_if and dts_wait_chain.
//
// One request is handled at a time. Pop and ignored run requests go from idle
// straight to finish, a run-now through remove when the task leaves the waiting
// list, a run-after-delay through calc, remove (if waiting) and insert, and a
// tick through expire, where the waiting-list cell row moves one expired head
// into the ready ring per cycle. The next request is taken while the previous
// response still sits in the output register. No clearing pass follows reset.
module deadline_task_scheduler #(
    parameter int NUM_TASKS = 16,
    parameter int TIME_BITS = 48
) (
    input  logic      clk,
    input  logic      rst_n,
    dts_req_if.sink   req,
    dts_rsp_if.source rsp
);
    localparam int PW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam int SW = ((TIME_BITS > dts_pkg::ScaleW) ? TIME_BITS : dts_pkg::ScaleW) + 1;
    localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

    dts_pkg::state_t state_reg, state_next;

    logic [TIME_BITS-1:0]       now_reg;
    logic [NUM_TASKS-1:0]       wait_mark_reg, pend_mark_reg;
    logic [dts_pkg::IdW-1:0]    ring_reg [NUM_TASKS];
    logic [PW-1:0]              head_reg;
    logic [CW-1:0]              count_reg;

    logic [1:0]                 cmd_reg;
    logic [dts_pkg::IdW-1:0]    id_reg;
    logic [dts_pkg::ScaleW-1:0] d_reg;
    logic [TIME_BITS-1:0]       at_reg;
    logic                       status_reg, rvalid_reg;
    logic [dts_pkg::IdW-1:0]    rtask_reg;

    logic                       rsp_valid_reg;
    logic                       rsp_status_reg, rsp_rvalid_reg, rsp_rempty_reg, rsp_wempty_reg;
    logic [dts_pkg::IdW-1:0]    rsp_rtask_reg;
    logic [dts_pkg::NdW-1:0]    rsp_nd_reg;

    dts_pkg::chain_ctl_t        ctl;
    logic [NUM_TASKS-1:0]       cell_valids;
    logic [dts_pkg::IdW-1:0]    head_id;
    logic [TIME_BITS-1:0]       head_dl;

    logic                       accept, push_en, pop_en, wclr_en, wset_en, load_rsp;
    logic [dts_pkg::IdW-1:0]    push_id, wclr_id;

    logic [7:0]                 req_id8, reg_id8, push_id8, clr_id8, pop_id8;
    logic [PW-1:0]              req_idx, reg_idx, push_idx, clr_idx, pop_idx;
    logic                       req_in_range, req_run, req_ignore, head_expired;
    logic [dts_pkg::IdW-1:0]    pop_task;
    logic [CW:0]                tail_sum;
    logic [PW-1:0]              tail_idx;
    logic [SW-1:0]              at_sum;
    logic [63:0]                head_dl64;

    // task ids index the mark vectors through a common 8-bit view
    assign req_id8  = {4'd0, req.task_id};
    assign reg_id8  = {4'd0, id_reg};
    assign push_id8 = {4'd0, push_id};
    assign clr_id8  = {4'd0, wclr_id};
    assign req_idx  = req_id8[PW-1:0];
    assign reg_idx  = reg_id8[PW-1:0];
    assign push_idx = push_id8[PW-1:0];
    assign clr_idx  = clr_id8[PW-1:0];

    assign pop_task = ring_reg[head_reg];
    assign pop_id8  = {4'd0, pop_task};
    assign pop_idx  = pop_id8[PW-1:0];

    assign req_in_range = (NUM_TASKS > 255) || (req_id8 < 8'(NUM_TASKS));
    assign req_run      = (req.command == dts_pkg::CMD_RUN_NOW) ||
                          (req.command == dts_pkg::CMD_RUN_AFTER);
    assign req_ignore   = req_run && (!req_in_range || pend_mark_reg[req_idx]);
    assign head_expired = cell_valids[0] && (head_dl <= now_reg);

    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign tail_idx = (tail_sum >= (CW+1)'(NUM_TASKS)) ?
                      PW'(tail_sum - (CW+1)'(NUM_TASKS)) : PW'(tail_sum);

    assign at_sum    = SW'(now_reg) + SW'(d_reg);
    assign head_dl64 = 64'(head_dl);

    assign accept = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        ctl.op     = dts_pkg::OP_NOP;
        ctl.id     = id_reg;
        push_en    = 1'b0;
        push_id    = id_reg;
        pop_en     = 1'b0;
        wclr_en    = 1'b0;
        wclr_id    = id_reg;
        wset_en    = 1'b0;
        load_rsp   = 1'b0;
        case (state_reg)
            dts_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    case (req.command)
                        dts_pkg::CMD_RUN_NOW:
                        begin
                            if (req_ignore)
                                state_next = dts_pkg::ST_FINISH;
                            else if (wait_mark_reg[req_idx])
                                state_next = dts_pkg::ST_REMOVE;
                            else
                            begin
                                push_en    = 1'b1;
                                push_id    = req.task_id;
                                state_next = dts_pkg::ST_FINISH;
                            end
                        end
                        dts_pkg::CMD_RUN_AFTER:
                            state_next = req_ignore ? dts_pkg::ST_FINISH : dts_pkg::ST_CALC;
                        dts_pkg::CMD_TICK:
                            state_next = dts_pkg::ST_EXPIRE;
                        default:
                        begin
                            pop_en     = count_reg != '0;
                            state_next = dts_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            dts_pkg::ST_CALC:
                state_next = wait_mark_reg[reg_idx] ? dts_pkg::ST_REMOVE : dts_pkg::ST_INSERT;
            dts_pkg::ST_REMOVE:
            begin
                ctl.op  = dts_pkg::OP_REMOVE;
                wclr_en = 1'b1;
                if (cmd_reg == dts_pkg::CMD_RUN_NOW)
                begin
                    push_en    = 1'b1;
                    state_next = dts_pkg::ST_FINISH;
                end
                else
                    state_next = dts_pkg::ST_INSERT;
            end
            dts_pkg::ST_INSERT:
            begin
                ctl.op     = dts_pkg::OP_INSERT;
                wset_en    = 1'b1;
                state_next = dts_pkg::ST_FINISH;
            end
            dts_pkg::ST_EXPIRE:
            begin
                // drain one expired head per cycle
                if (head_expired)
                begin
                    ctl.op  = dts_pkg::OP_SHIFT;
                    push_en = 1'b1;
                    push_id = head_id;
                    wclr_en = 1'b1;
                    wclr_id = head_id;
                end
                else
                    state_next = dts_pkg::ST_FINISH;
            end
            dts_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_rsp   = 1'b1;
                    state_next = dts_pkg::ST_IDLE;
                end
            end
            default:
                state_next = dts_pkg::ST_IDLE;
        endcase
    end

    dts_wait_chain #(.NUM_TASKS(NUM_TASKS), .TIME_BITS(TIME_BITS)) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .new_dl (at_reg),
        .valids (cell_valids),
        .head_id(head_id),
        .head_dl(head_dl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dts_pkg::ST_IDLE;
            now_reg       <= '0;
            wait_mark_reg <= '0;
            pend_mark_reg <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && (req.command == dts_pkg::CMD_TICK) && (now_reg != TimeMax))
                now_reg <= now_reg + 1'b1;
            if (wclr_en)
                wait_mark_reg[clr_idx] <= 1'b0;
            if (wset_en)
                wait_mark_reg[reg_idx] <= 1'b1;
            if (push_en && (count_reg != CW'(NUM_TASKS)))
            begin
                pend_mark_reg[push_idx] <= 1'b1;
                count_reg               <= count_reg + 1'b1;
            end
            if (pop_en)
            begin
                pend_mark_reg[pop_idx] <= 1'b0;
                count_reg              <= count_reg - 1'b1;
                head_reg <= (head_reg == PW'(NUM_TASKS - 1)) ? '0 : head_reg + 1'b1;
            end
            if (load_rsp)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en && (count_reg != CW'(NUM_TASKS)))
            ring_reg[tail_idx] <= push_id;
        if (accept)
        begin
            cmd_reg    <= req.command;
            id_reg     <= req.task_id;
            d_reg      <= req.delay_in_ms ?
                          dts_pkg::ScaleW'(req.delay) * dts_pkg::ScaleW'(dts_pkg::MsScale)
                          : dts_pkg::ScaleW'(req.delay);
            status_reg <= req_ignore;
            rvalid_reg <= pop_en;
            rtask_reg  <= pop_en ? pop_task : '0;
        end
        if (state_reg == dts_pkg::ST_CALC)
            at_reg <= (at_sum > SW'(TimeMax)) ? TimeMax : at_sum[TIME_BITS-1:0];
        if (load_rsp)
        begin
            rsp_status_reg <= status_reg;
            rsp_rvalid_reg <= rvalid_reg;
            rsp_rtask_reg  <= rtask_reg;
            rsp_rempty_reg <= count_reg == '0;
            rsp_wempty_reg <= !cell_valids[0];
            rsp_nd_reg     <= cell_valids[0] ? head_dl64[dts_pkg::NdW-1:0] : '0;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.ready_valid   = rsp_rvalid_reg;
    assign rsp.ready_task    = rsp_rtask_reg;
    assign rsp.ready_empty   = rsp_rempty_reg;
    assign rsp.waiting_empty = rsp_wempty_reg;
    assign rsp.next_deadline = rsp_nd_reg;

    a_wait_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dts_pkg::ST_IDLE) |->
            ($countones(wait_mark_reg) == $countones(cell_valids)))
        else $error("waiting marks disagree with occupied cells");

    a_pend_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dts_pkg::ST_IDLE) |->
            ($countones(pend_mark_reg) == 32'(count_reg)))
        else $error("pending marks disagree with ready count");

    a_expire_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == dts_pkg::ST_FINISH) && ($past(state_reg) == dts_pkg::ST_EXPIRE))
            |-> !head_expired)
        else $error("expired task left in waiting list");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NUM_TASKS))
        else $error("ready count above capacity");
endmodule
